>>> rtl/heatmap_peak_detect_unit_defines.svh
// Assertion macros for the heatmap peak detector.
// Expects clk and rst in scope at the point of use.
`ifndef HEATMAP_PEAK_DETECT_UNIT_DEFINES_SVH
`define HEATMAP_PEAK_DETECT_UNIT_DEFINES_SVH

// check in the same cycle
`define HPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check in the following cycle
`define HPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hpd_pkg.sv
// Shared constants, types and helpers of the heatmap peak detector.
// No dependencies.
`default_nettype none

package hpd_pkg;

  localparam int MAP_SIZE   = 16;
  localparam int COORD_W    = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
  localparam int SAMPLE_W   = 16;
  localparam int THR_W      = 15;
  localparam int TOTAL_W    = 8;
  localparam int CHAIN_LEN  = 2 * MAP_SIZE;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COORD_W-1:0] LAST_COORD = COORD_W'(MAP_SIZE - 1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1638);

  localparam logic KIND_PEAK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic REG_PEAK_THR  = 1'b0;
  localparam logic REG_VALID_THR = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic               item_kind;
    logic [3:0]         peak_row;
    logic [3:0]         peak_column;
    logic               map_valid;
    logic [TOTAL_W-1:0] peak_total;
    logic               last_of_run;
  } result_t;

  function automatic logic [3:0] to_coord4(input logic [COORD_W-1:0] x);
    logic [COORD_W+3:0] wide;
    wide = {4'b0000, x};
    return wide[3:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] x);
    return (x == {TOTAL_W{1'b1}}) ? x : x + TOTAL_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> rtl/hpd_sample_if.sv
// Sample and result channels of the heatmap peak detector.
// Depends on hpd_pkg.
`default_nettype none

interface hpd_sample_if import hpd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface hpd_result_if import hpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               item_kind;
  logic [3:0]         peak_row;
  logic [3:0]         peak_column;
  logic               map_valid;
  logic [TOTAL_W-1:0] peak_total;
  logic               last_of_run;

  modport source (output valid, output item_kind, output peak_row, output peak_column,
                  output map_valid, output peak_total, output last_of_run, input ready);
  modport sink (input valid, input item_kind, input peak_row, input peak_column,
                input map_valid, input peak_total, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/hpd_cell.sv
// One tap of the sample chain: holds a sample and hands it on per beat.
// Depends on hpd_pkg.
`default_nettype none

module hpd_cell import hpd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    shift,
  input  wire sample_t sample_in,
  output sample_t      sample_out
);

  always_ff @(posedge clk) begin
    if (shift) begin
      sample_out <= sample_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hpd_result_fifo.sv
// Small result queue between the peak logic and the output channel.
// Depends on hpd_pkg.
`default_nettype none

module hpd_result_fifo import hpd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_item,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_item
);

  result_t                slots [0:FIFO_DEPTH-1];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_CNT_W-1:0]  count;
  logic                   pop;
  logic                   do_push;

  assign full      = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign do_push   = push && !full;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      case ({do_push, pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/heatmap_peak_detect_unit.sv
// Heatmap peak detector: takes one sample per cycle, a map of MAP_SIZE x MAP_SIZE
// samples in row-major order, and reports each 4-neighbour peak one row late
// from a 2*MAP_SIZE tap chain, then one summary beat per map. Results leave
// through a 4-entry queue, one per cycle when taken. The last row is judged
// at once on the final sample; its peaks and the summary drain one per cycle
// while the queue has room, in the first row of the next map; input pauses only
// on a full queue or a drain still running into the next map's second row.
// Depends on hpd_pkg, hpd_sample_if, hpd_result_if, hpd_cell, hpd_result_fifo.
`default_nettype none
`include "heatmap_peak_detect_unit_defines.svh"

module heatmap_peak_detect_unit import hpd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  hpd_sample_if.sink                 samples,
  hpd_result_if.source               results,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  function automatic logic peak_test(input sample_t x, input sample_t u, input sample_t d,
                                     input sample_t l, input sample_t r,
                                     input logic [THR_W-1:0] thr);
    sample_t t;
    t = $signed({1'b0, thr});
    return (x > u) && (x > d) && (x > l) && (x > r) && (x > t);
  endfunction

  logic [THR_W-1:0]   peak_threshold;
  logic [THR_W-1:0]   valid_threshold;

  sample_t            tap [0:CHAIN_LEN];
  logic [COORD_W-1:0] row_cnt;
  logic [COORD_W-1:0] col_cnt;
  sample_t            map_maximum;
  sample_t            max_next;
  logic [TOTAL_W-1:0] peak_counter;

  logic [MAP_SIZE-1:0] row_flags;
  logic [MAP_SIZE-1:0] pend_mask;
  logic                summary_pending;
  logic [TOTAL_W-1:0]  sum_total;
  logic                sum_max_ok;
  logic [COORD_W-1:0]  pick_col;

  logic    in_acc;
  logic    map_end;
  logic    beat_peak;
  logic    drain_busy;
  logic    drain_push;
  logic    fifo_push;
  logic    fifo_full;
  logic    fifo_valid;
  logic    valid_summary;
  result_t push_item;
  result_t out_item;
  sample_t up_s;
  sample_t left_s;
  sample_t right_s;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VALID_THR) ? CFG_DATA_W'(valid_threshold)
                                              : CFG_DATA_W'(peak_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold  <= THR_RESET;
      valid_threshold <= THR_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_PEAK_THR:  peak_threshold  <= pwdata[THR_W-1:0];
        REG_VALID_THR: valid_threshold <= pwdata[THR_W-1:0];
        default:       peak_threshold  <= peak_threshold;
      endcase
    end
  end

  // sample chain
  assign tap[0] = samples.sample_value;

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_chain
    hpd_cell u_cell (
      .clk        (clk),
      .shift      (in_acc),
      .sample_in  (tap[i]),
      .sample_out (tap[i+1])
    );
  end

  assign drain_busy    = (pend_mask != '0) || summary_pending;
  assign samples.ready = drain_busy ? (row_cnt == '0) : !fifo_full;
  assign in_acc        = samples.valid && samples.ready;
  assign map_end       = in_acc && (row_cnt == LAST_COORD) && (col_cnt == LAST_COORD);

  // window around the cell one row back
  assign up_s    = (row_cnt > COORD_W'(1)) ? tap[CHAIN_LEN] : '0;
  assign left_s  = (col_cnt != '0) ? tap[MAP_SIZE+1] : '0;
  assign right_s = (col_cnt != LAST_COORD) ? tap[MAP_SIZE-1] : '0;
  assign beat_peak = in_acc && (row_cnt != '0) &&
                     peak_test(tap[MAP_SIZE], up_s, tap[0], left_s, right_s, peak_threshold);

  // last row, judged on its final sample with zero below
  for (genvar k = 0; k < MAP_SIZE; k++) begin : g_last_row
    sample_t lft;
    sample_t rgt;
    if (k > 0) begin : g_l
      assign lft = tap[MAP_SIZE-k];
    end else begin : g_l0
      assign lft = '0;
    end
    if (k < MAP_SIZE - 1) begin : g_r
      assign rgt = tap[MAP_SIZE-2-k];
    end else begin : g_r0
      assign rgt = '0;
    end
    assign row_flags[k] = peak_test(tap[MAP_SIZE-1-k], tap[CHAIN_LEN-1-k], '0, lft, rgt,
                                    peak_threshold);
  end

  assign max_next = (samples.sample_value > map_maximum) ? samples.sample_value : map_maximum;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt      <= '0;
      col_cnt      <= '0;
      map_maximum  <= SAMPLE_MIN;
      peak_counter <= '0;
    end else if (in_acc) begin
      if (col_cnt == LAST_COORD) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt == LAST_COORD) ? '0 : row_cnt + COORD_W'(1);
      end else begin
        col_cnt <= col_cnt + COORD_W'(1);
      end
      if (map_end) begin
        map_maximum  <= SAMPLE_MIN;
        peak_counter <= '0;
      end else begin
        map_maximum  <= max_next;
        peak_counter <= beat_peak ? sat_inc(peak_counter) : peak_counter;
      end
    end
  end

  // drain of last-row peaks and summary
  always_comb begin
    pick_col = '0;
    for (int k = MAP_SIZE - 1; k >= 0; k--) begin
      if (pend_mask[k]) begin
        pick_col = COORD_W'(k);
      end
    end
  end

  assign drain_push = drain_busy && !fifo_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mask       <= '0;
      summary_pending <= 1'b0;
    end else if (map_end) begin
      pend_mask       <= row_flags;
      summary_pending <= 1'b1;
    end else if (drain_push) begin
      if (pend_mask != '0) begin
        pend_mask <= pend_mask & (pend_mask - MAP_SIZE'(1));
      end else begin
        summary_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (map_end) begin
      sum_total  <= beat_peak ? sat_inc(peak_counter) : peak_counter;
      sum_max_ok <= (max_next >= $signed({1'b0, valid_threshold}));
    end else if (drain_push && (pend_mask != '0)) begin
      sum_total <= sat_inc(sum_total);
    end
  end

  always_comb begin
    push_item = '0;
    if (beat_peak) begin
      push_item.item_kind   = KIND_PEAK;
      push_item.peak_row    = to_coord4(row_cnt - COORD_W'(1));
      push_item.peak_column = to_coord4(col_cnt);
    end else if (pend_mask != '0) begin
      push_item.item_kind   = KIND_PEAK;
      push_item.peak_row    = to_coord4(LAST_COORD);
      push_item.peak_column = to_coord4(pick_col);
    end else begin
      push_item.item_kind   = KIND_SUMMARY;
      push_item.map_valid   = sum_max_ok && (sum_total != '0);
      push_item.peak_total  = sum_total;
      push_item.last_of_run = 1'b1;
    end
  end

  assign fifo_push = beat_peak || drain_push;

  hpd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_item (push_item),
    .full      (fifo_full),
    .out_valid (fifo_valid),
    .out_ready (results.ready),
    .out_item  (out_item)
  );

  assign results.valid       = fifo_valid;
  assign results.item_kind   = out_item.item_kind;
  assign results.peak_row    = out_item.peak_row;
  assign results.peak_column = out_item.peak_column;
  assign results.map_valid   = out_item.map_valid;
  assign results.peak_total  = out_item.peak_total;
  assign results.last_of_run = out_item.last_of_run;

  assign valid_summary = results.valid && (results.item_kind == KIND_SUMMARY) &&
                         results.map_valid;

  `HPD_ASSERT_NEXT(a_summary_armed, map_end, summary_pending, "summary not armed at map end")
  `HPD_ASSERT_NOW(a_one_source, beat_peak, !drain_busy, "peak beat during drain")
  `HPD_ASSERT_NOW(a_queue_room, fifo_push, !fifo_full, "push into full result queue")
  `HPD_ASSERT_NOW(a_valid_has_peaks, valid_summary, results.peak_total != '0, "valid map without peaks")

endmodule

`default_nettype wire
